>>> rtl/core/tcq_pkg.sv
// ----------------------------------------------------------------------------
// tcq_pkg
// Shared types and constants of the two-class FCFS scheduler.
// ----------------------------------------------------------------------------
package tcq_pkg;

  localparam int MAX_PROCS = 64;
  localparam int TIME_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ID_W      = 7;
  localparam int IN_T_W    = 16;
  localparam int CLK_W     = 23;
  localparam int SUM_W     = 29;

  typedef struct packed {
    logic              is_user;
    logic [IN_T_W-1:0] arrival;
    logic [IN_T_W-1:0] burst;
    logic              final_record;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]   proc_id;
    logic              out_is_user;
    logic [IN_T_W-1:0] out_arrival;
    logic [IN_T_W-1:0] out_burst;
    logic [CLK_W-1:0]  waiting;
    logic [CLK_W-1:0]  turnaround;
    logic [CLK_W-1:0]  completion;
    logic [SUM_W-1:0]  sum_waiting;
    logic [SUM_W-1:0]  sum_turnaround;
    logic              end_of_schedule;
  } result_t;

  // one table entry
  typedef struct packed {
    logic                 user;
    logic [TIME_BITS-1:0] arr;
    logic [TIME_BITS-1:0] svc;
    logic [ID_W-1:0]      id;
  } rec_t;

  // sequencer to timing datapath
  typedef struct packed {
    logic clear;
    logic valid;
    logic last;
  } fcfs_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDA,
    ST_LDA,
    ST_CMP,
    ST_WBA,
    ST_SERVE,
    ST_DRAIN
  } state_t;

endpackage

>>> rtl/core/tcq_fcfs.sv
// ----------------------------------------------------------------------------
// tcq_fcfs
// FCFS timing datapath: takes ordered records one per beat, keeps the
// service clock and running sums, and registers one result per record.
// ----------------------------------------------------------------------------
module tcq_fcfs (
  input  logic               clk,
  input  logic               rst,
  input  tcq_pkg::fcfs_ctl_t ctl,
  input  tcq_pkg::rec_t      rec,
  output tcq_pkg::result_t   result,
  output logic               result_strobe
);
  import tcq_pkg::*;

  logic [CLK_W-1:0] svc_clock;
  logic [CLK_W-1:0] arr_ext;
  logic [CLK_W-1:0] start_time;
  logic [CLK_W-1:0] compl_next;

  // stage 1
  logic             s1_valid;
  logic             s1_last;
  rec_t             s1_rec;
  logic [CLK_W-1:0] s1_wait;
  logic [CLK_W-1:0] s1_compl;

  // stage 2 running totals
  logic [SUM_W-1:0] sw;
  logic [SUM_W-1:0] st;
  logic [CLK_W-1:0] tat;
  logic [SUM_W-1:0] sw_next;
  logic [SUM_W-1:0] st_next;

  assign arr_ext    = CLK_W'(rec.arr);
  assign start_time = (svc_clock < arr_ext) ? arr_ext : svc_clock;
  assign compl_next = start_time + CLK_W'(rec.svc);

  assign tat     = s1_compl - CLK_W'(s1_rec.arr);
  assign sw_next = sw + SUM_W'(s1_wait);
  assign st_next = st + SUM_W'(tat);

  always_ff @(posedge clk) begin
    if (rst) begin
      svc_clock <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= ctl.valid;
      if (ctl.clear) begin
        svc_clock <= '0;
      end else if (ctl.valid) begin
        svc_clock <= compl_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      s1_rec   <= rec;
      s1_last  <= ctl.last;
      s1_wait  <= start_time - arr_ext;
      s1_compl <= compl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw            <= '0;
      st            <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= s1_valid;
      if (ctl.clear) begin
        sw <= '0;
        st <= '0;
      end else if (s1_valid) begin
        sw <= sw_next;
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      result.proc_id         <= s1_rec.id;
      result.out_is_user     <= s1_rec.user;
      result.out_arrival     <= IN_T_W'(s1_rec.arr);
      result.out_burst       <= IN_T_W'(s1_rec.svc);
      result.waiting         <= s1_wait;
      result.turnaround      <= tat;
      result.completion      <= s1_compl;
      result.sum_waiting     <= sw_next;
      result.sum_turnaround  <= st_next;
      result.end_of_schedule <= s1_last;
    end
  end

`ifndef SYNTH
  a_tat_split: assert property (@(posedge clk) disable iff (rst)
    result_strobe |->
      result.turnaround == result.waiting + CLK_W'(result.out_burst))
    else $error("turnaround is not waiting plus burst");

  a_compl_order: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> result.completion >= CLK_W'(result.out_arrival))
    else $error("completion before arrival");
`endif

endmodule

>>> rtl/core/two_class_queue_fcfs_scheduler.sv
// Loading: one record per cycle, busy stays low until the final record.
// After the final record of n: an exchange sort compares each pair of entries, with
// entry loads and write-backs on the table (one read port and one write port),
// then n table reads at one per cycle; each read passes through rdata, stage 1
// and the result register. Results leave one per cycle and cannot be stalled.
// Synchronous reset clears the record count and the sequencer; the table is not cleared.
// ----------------------------------------------------------------------------
// two_class_queue_fcfs_scheduler
// Loads process records into a table, orders them system-first and by
// arrival with an exchange sort, then emits FCFS timing per record.
// ----------------------------------------------------------------------------
module two_class_queue_fcfs_scheduler (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tcq_pkg::item_t   item,
  output tcq_pkg::result_t result,
  output logic             result_strobe
);
  import tcq_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] a, a_next;
  logic [IDX_W-1:0] b, b_next;
  logic [IDX_W-1:0] k, k_next;
  rec_t             cur, cur_next;

  // record table
  rec_t             mem [MAX_PROCS];
  rec_t             rdata;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rec_t             wr_data;

  logic             rd_valid, rd_valid_next;
  logic             rd_last, rd_last_next;
  logic             accept;
  logic             full;
  logic             swap;
  logic [CNT_W-1:0] n_after;
  fcfs_ctl_t        ctl;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(MAX_PROCS));
  assign n_after = full ? count : count + CNT_W'(1);

  // entry a (held in cur) moves behind entry b
  assign swap = (cur.user && !rdata.user) ||
                ((cur.user == rdata.user) && (cur.arr > rdata.arr));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rd_valid <= rd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    a       <= a_next;
    b       <= b_next;
    k       <= k_next;
    cur     <= cur_next;
    rd_last <= rd_last_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    a_next        = a;
    b_next        = b;
    k_next        = k;
    cur_next      = cur;
    rd_valid_next = 1'b0;
    rd_last_next  = rd_last;
    rd_en         = 1'b0;
    rd_addr       = a;
    wr_en         = 1'b0;
    wr_addr       = a;
    wr_data       = cur;
    ctl.clear     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!full) begin
            wr_en        = 1'b1;
            wr_addr      = count[IDX_W-1:0];
            wr_data.user = item.is_user;
            wr_data.arr  = item.arrival[TIME_BITS-1:0];
            wr_data.svc  = item.burst[TIME_BITS-1:0];
            wr_data.id   = ID_W'(count + CNT_W'(1));
          end
          count_next = n_after;
          if (item.final_record) begin
            ctl.clear = 1'b1;
            a_next    = '0;
            b_next    = IDX_W'(1);
            k_next    = '0;
            state_next = (n_after < CNT_W'(2)) ? ST_SERVE : ST_RDA;
          end
        end
      end
      ST_RDA: begin
        rd_en      = 1'b1;
        rd_addr    = a;
        state_next = ST_LDA;
      end
      ST_LDA: begin
        cur_next   = rdata;
        rd_en      = 1'b1;
        rd_addr    = b;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (swap) begin
          wr_en    = 1'b1;
          wr_addr  = b;
          wr_data  = cur;
          cur_next = rdata;
        end
        if (CNT_W'(b) + CNT_W'(1) == count) begin
          state_next = ST_WBA;
        end else begin
          rd_en   = 1'b1;
          rd_addr = b + IDX_W'(1);
          b_next  = b + IDX_W'(1);
        end
      end
      ST_WBA: begin
        wr_en   = 1'b1;
        wr_addr = a;
        wr_data = cur;
        if (CNT_W'(a) + CNT_W'(2) < count) begin
          a_next     = a + IDX_W'(1);
          b_next     = a + IDX_W'(2);
          state_next = ST_RDA;
        end else begin
          state_next = ST_SERVE;
        end
      end
      ST_SERVE: begin
        rd_en         = 1'b1;
        rd_addr       = k;
        rd_valid_next = 1'b1;
        rd_last_next  = (CNT_W'(k) + CNT_W'(1) == count);
        if (CNT_W'(k) + CNT_W'(1) == count) begin
          count_next = '0;
          state_next = ST_DRAIN;
        end else begin
          k_next = k + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (result_strobe && result.end_of_schedule) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    ctl.valid = rd_valid;
    ctl.last  = rd_last;
  end

  tcq_fcfs u_fcfs (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .rec           (rdata),
    .result        (result),
    .result_strobe (result_strobe)
  );

`ifndef SYNTH
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result beat while idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PROCS))
    else $error("record count beyond table depth");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.end_of_schedule) |=> !busy)
    else $error("still busy after last result");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (a < b) && (CNT_W'(b) < count))
    else $error("compare pair out of order");
`endif

endmodule
